// ----- rtl/lie_pkg.sv -----
// Shared constants, codes and types of the list intersection engine.
`default_nettype none

package lie_pkg;

    // List capacity and derived widths
    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int OP_W       = 2;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN           = 2'd2;

    // Value reported when a run finds nothing in common
    localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

    // Controls shared by every cell of the second-list ring
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage : lie_pkg

`default_nettype wire

// ----- rtl/lie_cell.sv -----
// One cell of the second-list ring: an entry, its valid bit and its matched mark.
`default_nettype none

module lie_cell
    import lie_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cell_ctl_t                 ctl,
    input  wire logic                      load_en,
    input  wire logic signed [VALUE_W-1:0] load_value,
    input  wire logic signed [VALUE_W-1:0] nxt_value,
    input  wire logic                      nxt_matched,
    input  wire logic                      nxt_valid,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           matched,
    output logic                           valid
);

    logic signed [VALUE_W-1:0] value_reg;
    logic                      matched_reg;
    logic                      valid_reg;

    // Entry value: load on append, take the neighbour's on shift
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            value_reg <= load_value;
        end
        else if (ctl.shift)
        begin
            value_reg <= nxt_value;
        end
    end

    // Valid bit and matched mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            matched_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (load_en)
        begin
            matched_reg <= 1'b0;
            valid_reg   <= 1'b1;
        end
        else if (ctl.shift)
        begin
            matched_reg <= nxt_matched;
            valid_reg   <= nxt_valid;
        end
    end

    assign value   = value_reg;
    assign matched = matched_reg;
    assign valid   = valid_reg;

endmodule : lie_cell

`default_nettype wire

// ----- rtl/lie_first_mem.sv -----
// Storage of the first list: one write port, one registered read port.
`default_nettype none

module lie_first_mem
    import lie_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_addr,
    input  wire logic signed [VALUE_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]          rd_addr,
    output logic signed [VALUE_W-1:0]      rd_data
);

    logic signed [VALUE_W-1:0] mem [LIST_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Write on append
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : lie_first_mem

`default_nettype wire

// ----- rtl/list_intersection_engine_unit.sv -----
// Top level of the list intersection engine: item decode, ring of cells, run sequencer.
`default_nettype none

// Append beats (op 0 or 1) are accepted back to back; op 3 is taken and
// ignored. A run beat holds the input off until the run ends, longer while the
// output is stalled: for each first-list entry, ST_LOAD reads the entry from
// memory and ST_SCAN rotates the whole second-list ring of cells once past
// the head comparator, one entry per cycle while the output is not stalled.
// Results leave through an output register; the final result of a run is
// held back until the scan ends so that it can carry tlast. A run with
// nothing in common returns one beat with none_found set and a value of all
// ones. Every run clears both lists, the marks and the overflow flag.
module list_intersection_engine_unit
    import lie_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] value
    input  wire logic [1:0]   s_tuser,   // [1:0] op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // [31:0] match_value
    output logic [1:0]        m_tuser,   // [0] none_found, [1] overflow
    output logic              m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          first_count_reg, first_count_next;
    logic [CNT_W-1:0]          second_count_reg, second_count_next;
    logic                      overflow_reg, overflow_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic signed [VALUE_W-1:0] pend_value_reg, pend_value_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_none_reg, out_none_next;
    logic                      out_ovf_reg, out_ovf_next;
    logic                      out_last_reg, out_last_next;

    logic                      in_beat;
    logic [OP_W-1:0]           in_op;
    logic signed [VALUE_W-1:0] in_value;
    logic                      first_full;
    logic                      second_full;
    logic                      wr_first;
    logic                      wr_second;
    logic                      out_free;
    logic signed [VALUE_W-1:0] first_value;
    logic                      head_hit;
    logic                      last_i;
    cell_ctl_t                 ring_ctl;

    logic signed [VALUE_W-1:0] cell_value   [LIST_DEPTH];
    logic                      cell_matched [LIST_DEPTH];
    logic                      cell_valid   [LIST_DEPTH];

    // Decode the input beat
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_beat     = s_tvalid && s_tready;
    assign in_op       = s_tuser;
    assign in_value    = $signed(s_tdata);
    assign first_full  = (first_count_reg == CNT_W'(LIST_DEPTH));
    assign second_full = (second_count_reg == CNT_W'(LIST_DEPTH));
    assign wr_first    = in_beat && (in_op == OP_APPEND_FIRST) && !first_full;
    assign wr_second   = in_beat && (in_op == OP_APPEND_SECOND) && !second_full;
    assign out_free    = !out_valid_reg || m_tready;

    // First list storage
    lie_first_mem u_first_mem (
        .clk     (clk),
        .wr_en   (wr_first),
        .wr_addr (first_count_reg[IDX_W-1:0]),
        .wr_data (in_value),
        .rd_addr (i_reg),
        .rd_data (first_value)
    );

    // Head comparison: entry at cell 0 against the current first-list value
    assign head_hit = cell_valid[0] && !cell_matched[0] && (cell_value[0] == first_value);

    assign ring_ctl.shift = (state_reg == ST_SCAN) && out_free;
    assign ring_ctl.clear = (state_reg == ST_FINISH) && out_free;

    // Second list as a ring of cells, rotating towards cell 0
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] nv;
        logic                      nm;
        logic                      nvld;

        if (g == LIST_DEPTH - 1)
        begin : g_wrap
            assign nv   = cell_value[0];
            assign nm   = cell_matched[0] || head_hit;
            assign nvld = cell_valid[0];
        end
        else
        begin : g_link
            assign nv   = cell_value[g+1];
            assign nm   = cell_matched[g+1];
            assign nvld = cell_valid[g+1];
        end

        lie_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ring_ctl),
            .load_en     (wr_second && (second_count_reg[IDX_W-1:0] == IDX_W'(g))),
            .load_value  (in_value),
            .nxt_value   (nv),
            .nxt_matched (nm),
            .nxt_valid   (nvld),
            .value       (cell_value[g]),
            .matched     (cell_matched[g]),
            .valid       (cell_valid[g])
        );
    end

    assign last_i = ((CNT_W'(i_reg) + CNT_W'(1)) == first_count_reg);

    // Run sequencer, list counts and output register
    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        pend_valid_next   = pend_valid_reg;
        pend_value_next   = pend_value_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_value_next    = out_value_reg;
        out_none_next     = out_none_reg;
        out_ovf_next      = out_ovf_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (in_op)
                        OP_APPEND_FIRST:
                        begin
                            if (first_full)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                first_count_next = first_count_reg + CNT_W'(1);
                            end
                        end
                        OP_APPEND_SECOND:
                        begin
                            if (second_full)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                second_count_next = second_count_reg + CNT_W'(1);
                            end
                        end
                        OP_RUN:
                        begin
                            i_next = '0;
                            k_next = '0;
                            state_next = (first_count_reg == '0) ? ST_FINISH : ST_LOAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                k_next     = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (out_free)
                begin
                    // Hold the newest match back; release the one before it
                    if (head_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = pend_value_reg;
                            out_none_next  = 1'b0;
                            out_ovf_next   = overflow_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = cell_value[0];
                    end
                    k_next = k_reg + IDX_W'(1);
                    if (k_reg == IDX_W'(LIST_DEPTH - 1))
                    begin
                        if (last_i)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_value_next    = pend_valid_reg ? pend_value_reg : NONE_VALUE;
                    out_none_next     = !pend_valid_reg;
                    out_ovf_next      = overflow_reg;
                    out_last_next     = 1'b1;
                    pend_valid_next   = 1'b0;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            i_reg            <= '0;
            k_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            i_reg            <= i_next;
            k_reg            <= k_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_value_reg  <= out_value_next;
        out_none_reg   <= out_none_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_ovf_reg, out_none_reg};
    assign m_tlast  = out_last_reg;

    // Input is only taken while no run is in progress
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted during a run");

    // A none-found beat always closes its run
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_none_reg) |-> out_last_reg)
        else $error("none-found beat without last");

    // Finishing a run clears both lists
    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=>
            ((state_reg == ST_IDLE) && (first_count_reg == '0) && (second_count_reg == '0)
             && !pend_valid_reg && out_valid_reg && out_last_reg))
        else $error("run did not finish cleanly");

    // A held-back match exists only inside a run
    a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != ST_IDLE))
        else $error("pending match left over after a run");

endmodule : list_intersection_engine_unit

`default_nettype wire

// ----- verif/tb_list_intersection_engine_unit.sv -----
// Self-checking testbench of the list intersection engine: directed and random list runs.
`default_nettype none

module tb_list_intersection_engine_unit;
    import lie_pkg::*;

    // Opcode that the block takes and ignores
    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    // Extreme element values
    localparam logic [VALUE_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX     = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_NEG_ONE = 32'hffff_ffff;
    localparam logic [VALUE_W-1:0] VAL_ZERO    = 32'h0000_0000;
    localparam int ITEM_TARGET   = 460;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;

    // One result beat as the block should present it
    typedef struct packed {
        logic [VALUE_W-1:0] match_value;
        logic               none_found;
        logic               overflow;
        logic               last;
    } isect_result_t;

    // Shadow of both lists; predicts the beats of every run
    class intersect_scoreboard;
        logic [VALUE_W-1:0] first_vals[$];
        logic [VALUE_W-1:0] second_vals[$];
        bit                 dropped;
        isect_result_t      awaited[$];
        int unsigned        fails;

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Walk the first list; each unclaimed equal second-list entry is one beat
        function void scan_lists();
            bit            claimed[LIST_DEPTH];
            isect_result_t batch[$];
            isect_result_t r;
            foreach (claimed[k])
                claimed[k] = 1'b0;
            foreach (first_vals[i])
                foreach (second_vals[k])
                    if (!claimed[k] && second_vals[k] == first_vals[i])
                    begin
                        claimed[k] = 1'b1;
                        batch.push_back('{second_vals[k], 1'b0, dropped, 1'b0});
                    end
            if (batch.size() == 0)
                batch.push_back('{NONE_VALUE, 1'b1, dropped, 1'b1});
            else
            begin
                r = batch.pop_back();
                r.last = 1'b1;
                batch.push_back(r);
            end
            foreach (batch[j])
                awaited.push_back(batch[j]);
            first_vals.delete();
            second_vals.delete();
            dropped = 1'b0;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
            case (op)
                OP_APPEND_FIRST:
                    if (first_vals.size() < LIST_DEPTH)
                        first_vals.push_back(value);
                    else
                        dropped = 1'b1;
                OP_APPEND_SECOND:
                    if (second_vals.size() < LIST_DEPTH)
                        second_vals.push_back(value);
                    else
                        dropped = 1'b1;
                OP_RUN:
                    scan_lists();
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [VALUE_W-1:0] value, logic none_found,
                                   logic overflow, logic last);
            isect_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result beat with nothing awaited: match_value %0h", value);
                fails++;
                return;
            end
            want = awaited.pop_front();
            if (value !== want.match_value)
            begin
                $error("match_value: expected %0h, got %0h", want.match_value, value);
                fails++;
            end
            if (none_found !== want.none_found)
            begin
                $error("none_found: expected %0b, got %0b", want.none_found, none_found);
                fails++;
            end
            if (overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                fails++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, last);
                fails++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    intersect_scoreboard sb = new();
    logic [VALUE_W-1:0]  value_pool[$];
    bit                  steady;
    int unsigned         items_sent;
    int unsigned         cycle_count;

    list_intersection_engine_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one beat, idling first at random; hold it until taken.
    // The prediction is made as the beat goes on the bus: it cannot be withdrawn,
    // and after a run beat is taken the task waits until its scan is over.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        sb.note_item(op, value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Hold the bus idle until every awaited beat has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Element value: mostly from a small pool so that lists share values
    function automatic logic [VALUE_W-1:0] draw_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return $urandom();
        if (roll < 16)
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_NEG_ONE;
                default: return VAL_ZERO;
            endcase
        return value_pool[$urandom_range(value_pool.size() - 1)];
    endfunction

    // List length: mostly short, now and then near or past capacity
    function automatic int unsigned draw_length();
        if ($urandom_range(99) < 10)
            return $urandom_range(LIST_DEPTH + 8, LIST_DEPTH - 4);
        return $urandom_range(6);
    endfunction

    // Fill both lists, interleaved, with a little noise, then run
    task automatic send_list_pair();
        int unsigned n_first;
        int unsigned n_second;
        n_first  = draw_length();
        n_second = draw_length();
        value_pool.delete();
        repeat ($urandom_range(6, 1))
            value_pool.push_back($urandom());
        while (n_first + n_second > 0)
        begin
            if ($urandom_range(99) < 4)
                send_item(OP_UNUSED, $urandom());
            if (n_second == 0 || (n_first != 0 && $urandom_range(1) == 1))
            begin
                send_item(OP_APPEND_FIRST, draw_value());
                n_first--;
            end
            else
            begin
                send_item(OP_APPEND_SECOND, draw_value());
                n_second--;
            end
        end
        if ($urandom_range(3) == 0)
            drain_results();
        send_item(OP_RUN, $urandom());
    endtask

    // Stimulus
    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= OP_APPEND_FIRST;
        steady     = 1'b0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Run on empty lists, then an ignored opcode
        send_item(OP_RUN, $urandom());
        send_item(OP_UNUSED, VAL_NEG_ONE);
        // First list empty
        send_item(OP_APPEND_SECOND, 32'd7);
        send_item(OP_RUN, VAL_ZERO);
        // Extremes, repeated INT_MAX in the second list
        send_item(OP_APPEND_FIRST, VAL_MIN);
        send_item(OP_APPEND_FIRST, VAL_MAX);
        send_item(OP_APPEND_FIRST, VAL_ZERO);
        send_item(OP_APPEND_FIRST, VAL_NEG_ONE);
        send_item(OP_APPEND_SECOND, VAL_NEG_ONE);
        send_item(OP_APPEND_SECOND, VAL_MAX);
        send_item(OP_APPEND_SECOND, VAL_MAX);
        send_item(OP_APPEND_SECOND, 32'd5);
        send_item(OP_APPEND_SECOND, VAL_MIN);
        send_item(OP_RUN, VAL_MAX);
        // Both lists filled, nothing in common
        send_item(OP_APPEND_FIRST, 32'd1);
        send_item(OP_APPEND_FIRST, 32'd2);
        send_item(OP_APPEND_SECOND, 32'd3);
        send_item(OP_RUN, VAL_MIN);
        // Repeated first-list value claims its partner only once
        send_item(OP_APPEND_FIRST, 32'd9);
        send_item(OP_APPEND_FIRST, 32'd9);
        send_item(OP_APPEND_SECOND, 32'd9);
        send_item(OP_RUN, 32'd9);
        drain_results();

        // Random sets, with some broken sequences of raw items
        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 180 && items_sent < 270);
            if ($urandom_range(99) < 85)
                send_list_pair();
            else
                repeat ($urandom_range(8, 1))
                    send_item(OP_W'($urandom_range(3)), $urandom());
        end
        steady = 1'b0;

        // Settle and report
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: check each taken beat, stall at random
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            m_tready <= steady || ($urandom_range(99) >= 27);
        end
    end

    // Cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule : tb_list_intersection_engine_unit

`default_nettype wire
